// ===== rtl/dlwp_pkg.sv =====
// Shared types and codes for the heaviest-path unit.
// Used by dlwp_ctrl, dlwp_datapath and dag_longest_weighted_path_unit.
package dlwp_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_NODE = 2'd0,
      OP_LOAD_EDGE = 2'd1,
      OP_COMPUTE   = 2'd2,
      OP_CLEAR     = 2'd3
   } opcode_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam int unsigned COUNT_W = 11;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [9:0]  source_node;
      logic [9:0]  dest_node;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [63:0] longest_weight;
      logic        saturated;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_ACCEPT, DP_EDGE_WRITE, DP_PREP,
      DP_ROOT_READ, DP_ROOT_CHECK, DP_WALK, DP_POP, DP_EDGE_CHECK,
      DP_VISIT, DP_PUSH, DP_RELAX_INIT, DP_RELAX_NODE, DP_RELAX_U,
      DP_RELAX_UDATA, DP_RELAX_EDGE, DP_RELAX_T, DP_RELAX_ADD,
      DP_RELAX_CMP, DP_MAX_READ, DP_MAX_CMP
   } dp_op_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_EDGE, S_PREP, S_ROOT_RD, S_ROOT_CHK, S_WALK,
      S_POP, S_EDGE_CHK, S_VIS_CHK, S_PUSH, S_RELAX_INIT, S_RELAX_NODE,
      S_RELAX_U, S_RELAX_UDATA, S_RELAX_EDGE, S_RELAX_T, S_RELAX_ADD,
      S_RELAX_CMP, S_MAX_RD, S_MAX_CMP, S_REPORT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic sweep_last;
      logic prep_last;
      logic root_visited;
      logic root_last;
      logic top_done;
      logic sp_one;
      logic tgt_ok;
      logic vis_ok;
      logic ridx_zero;
      logic edge_none;
      logic max_last;
   } stat_type;

endpackage

// ===== rtl/dlwp_ctrl.sv =====
// Sequencer of the heaviest-path unit: issues one datapath command per cycle.
// Depends on dlwp_pkg.
module dlwp_ctrl import dlwp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_opcode,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NOP;
      busy      = (state_ff != S_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = DP_ACCEPT;
               case (opcode_type'(req_opcode))
                  OP_LOAD_EDGE: state_in = S_EDGE;
                  OP_CLEAR:     state_in = S_CLEAR;
                  OP_COMPUTE:   state_in = stat.n_zero ? S_REPORT : S_PREP;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_EDGE: begin
            cmd.op   = DP_EDGE_WRITE;
            state_in = S_IDLE;
         end
         S_PREP: begin
            cmd.op = DP_PREP;
            if (stat.prep_last) state_in = S_ROOT_RD;
         end
         S_ROOT_RD: begin
            cmd.op   = DP_ROOT_READ;
            state_in = S_ROOT_CHK;
         end
         S_ROOT_CHK: begin
            cmd.op = DP_ROOT_CHECK;
            if (!stat.root_visited) state_in = S_WALK;
            else if (stat.root_last) state_in = S_RELAX_INIT;
            else state_in = S_ROOT_RD;
         end
         S_WALK: begin
            cmd.op = DP_WALK;
            if (!stat.top_done) state_in = S_EDGE_CHK;
            else if (!stat.sp_one) state_in = S_POP;
            else if (stat.root_last) state_in = S_RELAX_INIT;
            else state_in = S_ROOT_RD;
         end
         S_POP: begin
            cmd.op   = DP_POP;
            state_in = S_WALK;
         end
         S_EDGE_CHK: begin
            cmd.op   = DP_EDGE_CHECK;
            state_in = stat.tgt_ok ? S_VIS_CHK : S_WALK;
         end
         S_VIS_CHK: begin
            cmd.op   = DP_VISIT;
            state_in = stat.vis_ok ? S_PUSH : S_WALK;
         end
         S_PUSH: begin
            cmd.op   = DP_PUSH;
            state_in = S_WALK;
         end
         S_RELAX_INIT: begin
            cmd.op   = DP_RELAX_INIT;
            state_in = S_RELAX_NODE;
         end
         S_RELAX_NODE: begin
            cmd.op   = DP_RELAX_NODE;
            state_in = stat.ridx_zero ? S_MAX_RD : S_RELAX_U;
         end
         S_RELAX_U: begin
            cmd.op   = DP_RELAX_U;
            state_in = S_RELAX_UDATA;
         end
         S_RELAX_UDATA: begin
            cmd.op   = DP_RELAX_UDATA;
            state_in = S_RELAX_EDGE;
         end
         S_RELAX_EDGE: begin
            cmd.op   = DP_RELAX_EDGE;
            state_in = stat.edge_none ? S_RELAX_NODE : S_RELAX_T;
         end
         S_RELAX_T: begin
            cmd.op   = DP_RELAX_T;
            state_in = stat.tgt_ok ? S_RELAX_ADD : S_RELAX_EDGE;
         end
         S_RELAX_ADD: begin
            cmd.op   = DP_RELAX_ADD;
            state_in = S_RELAX_CMP;
         end
         S_RELAX_CMP: begin
            cmd.op   = DP_RELAX_CMP;
            state_in = S_RELAX_EDGE;
         end
         S_MAX_RD: begin
            cmd.op   = DP_MAX_READ;
            state_in = S_MAX_CMP;
         end
         S_MAX_CMP: begin
            cmd.op   = DP_MAX_CMP;
            state_in = stat.max_last ? S_REPORT : S_MAX_RD;
         end
         S_REPORT: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/dlwp_datapath.sv =====
// Graph stores, walk stack, counters and the saturating adder of the unit.
// Depends on dlwp_pkg; driven by dlwp_ctrl commands.
module dlwp_datapath import dlwp_pkg::*; #(
   parameter int unsigned MAX_NODES = 1024,
   parameter int unsigned MAX_EDGES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  req_type            req_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   output stat_type           stat,
   output rsp_type            rsp_data
);

   localparam int unsigned NW  = $clog2(MAX_NODES);
   localparam int unsigned NCW = NW + 1;
   localparam int unsigned EW  = $clog2(MAX_EDGES);
   localparam int unsigned EPW = EW + 1;
   localparam int unsigned SW  = NW + EPW;
   localparam logic [EPW-1:0] EDGE_NONE = EPW'(MAX_EDGES);
   localparam logic [NCW-1:0] NODE_MAX  = NCW'(MAX_NODES);

   // Stores
   logic [31:0]  node_value_ff [MAX_NODES];
   logic [63:0]  best_sum_ff   [MAX_NODES];
   logic [EPW-1:0] edge_head_ff [MAX_NODES];
   logic [EPW-1:0] edge_link_ff [MAX_EDGES];
   logic [NW-1:0]  edge_target_ff [MAX_EDGES];
   logic [31:0]  edge_weight_ff [MAX_EDGES];
   logic         visited_ff    [MAX_NODES];
   logic [NW-1:0] postorder_ff [MAX_NODES];
   logic [SW-1:0] stack_ff     [MAX_NODES];

   logic [31:0]    nv_rd_ff;
   logic [63:0]    best_rd_ff;
   logic [EPW-1:0] head_rd_ff;
   logic [EPW-1:0] link_rd_ff;
   logic [NW-1:0]  tgt_rd_ff;
   logic [31:0]    wgt_rd_ff;
   logic           vis_rd_ff;
   logic [NW-1:0]  po_rd_ff;
   logic [SW-1:0]  stk_rd_ff;

   // Control registers
   logic [COUNT_W-1:0] csr_count_ff;
   logic [1:0]     flags_ff, flags_in;
   logic [EPW-1:0] ecount_ff;
   logic [NCW-1:0] cnt_ff;
   logic [NW-1:0]  root_ff;
   logic [NCW-1:0] sp_ff;
   logic [NCW-1:0] pc_ff;
   logic [NCW-1:0] ridx_ff;
   logic           prep_wr_ff;
   logic [NW-1:0]  prep_addr_ff;

   // Payload registers
   req_type        req_ff;
   logic [NW-1:0]  top_node_ff;
   logic [EPW-1:0] top_next_ff;
   logic [NW-1:0]  t_ff;
   logic [NW-1:0]  u_ff;
   logic [EPW-1:0] e_ff;
   logic [63:0]    bu_ff;
   logic [64:0]    sum1_ff;
   logic [63:0]    c_ff;
   logic [63:0]    best_ff;
   logic           sat_ff;

   logic [NCW-1:0] n_w;
   logic           src_ok, edge_ok;
   logic [63:0]    s1_w;
   logic [64:0]    s2_w;
   logic           better_w;

   // Memory port controls
   logic           nv_we, nv_re;
   logic [NW-1:0]  nv_wa, nv_ra;
   logic [31:0]    nv_wd;
   logic           head_we, head_re;
   logic [NW-1:0]  head_wa, head_ra;
   logic [EPW-1:0] head_wd;
   logic           best_we, best_re;
   logic [NW-1:0]  best_wa, best_ra;
   logic [63:0]    best_wd;
   logic           vis_we, vis_re;
   logic [NW-1:0]  vis_wa, vis_ra;
   logic           vis_wd;
   logic           edge_we, edge_re;
   logic [EW-1:0]  edge_ra;
   logic           po_we, po_re;
   logic [NW-1:0]  po_ra;
   logic           stk_we, stk_re;
   logic [NW-1:0]  stk_wa, stk_ra;

   assign n_w = (32'(csr_count_ff) >= 32'(MAX_NODES)) ? NODE_MAX : NCW'(csr_count_ff);
   assign src_ok = 32'(req_data.source_node) < 32'(n_w);
   assign edge_ok = (32'(req_ff.source_node) < 32'(n_w))
                    && (32'(req_ff.dest_node) < 32'(n_w));

   assign s1_w     = sum1_ff[64] ? '1 : sum1_ff[63:0];
   assign s2_w     = {1'b0, s1_w} + {33'd0, nv_rd_ff};
   assign better_w = c_ff > best_rd_ff;

   always_comb begin
      stat.n_zero       = (n_w == '0);
      stat.sweep_last   = (cnt_ff == NCW'(MAX_NODES - 1));
      stat.prep_last    = (cnt_ff + NCW'(1) == n_w);
      stat.root_visited = vis_rd_ff;
      stat.root_last    = ({1'b0, root_ff} + NCW'(1) == n_w);
      stat.top_done     = (top_next_ff >= EDGE_NONE);
      stat.sp_one       = (sp_ff == NCW'(1));
      stat.tgt_ok       = ({1'b0, tgt_rd_ff} < n_w);
      stat.vis_ok       = !vis_rd_ff && (sp_ff < NODE_MAX);
      stat.ridx_zero    = (ridx_ff == '0);
      stat.edge_none    = (e_ff >= EDGE_NONE);
      stat.max_last     = (cnt_ff == n_w);
   end

   assign rsp_data.longest_weight = best_ff;
   assign rsp_data.saturated      = sat_ff;
   assign rsp_data.status         = flags_ff[1] ? STATUS_RANGE :
                                    (flags_ff[0] ? STATUS_FULL : STATUS_OK);

   // Port selection
   always_comb begin
      nv_we = 1'b0; nv_wa = cnt_ff[NW-1:0]; nv_wd = '0;
      nv_re = 1'b0; nv_ra = cnt_ff[NW-1:0];
      head_we = 1'b0; head_wa = cnt_ff[NW-1:0]; head_wd = EDGE_NONE;
      head_re = 1'b0; head_ra = root_ff;
      best_we = prep_wr_ff; best_wa = prep_addr_ff; best_wd = 64'(nv_rd_ff);
      best_re = 1'b0; best_ra = cnt_ff[NW-1:0];
      vis_we = 1'b0; vis_wa = cnt_ff[NW-1:0]; vis_wd = 1'b0;
      vis_re = 1'b0; vis_ra = root_ff;
      edge_we = 1'b0; edge_re = 1'b0; edge_ra = top_next_ff[EW-1:0];
      po_we = 1'b0; po_re = 1'b0; po_ra = '0;
      stk_we = 1'b0; stk_wa = '0; stk_re = 1'b0; stk_ra = '0;
      case (cmd.op)
         DP_CLEAR: begin
            nv_we   = 1'b1;
            head_we = 1'b1;
         end
         DP_ACCEPT: begin
            if (opcode_type'(req_data.opcode) == OP_LOAD_NODE && src_ok) begin
               nv_we = 1'b1;
               nv_wa = NW'(req_data.source_node);
               nv_wd = req_data.item_value;
            end
            head_re = 1'b1;
            head_ra = NW'(req_data.source_node);
         end
         DP_EDGE_WRITE: begin
            if (edge_ok && ecount_ff != EDGE_NONE) begin
               edge_we = 1'b1;
               head_we = 1'b1;
               head_wa = NW'(req_ff.source_node);
               head_wd = ecount_ff;
            end
         end
         DP_PREP: begin
            nv_re  = 1'b1;
            vis_we = 1'b1;
         end
         DP_ROOT_READ: begin
            vis_re  = 1'b1;
            head_re = 1'b1;
         end
         DP_ROOT_CHECK: begin
            if (!vis_rd_ff) begin
               vis_we = 1'b1;
               vis_wa = root_ff;
               vis_wd = 1'b1;
            end
         end
         DP_WALK: begin
            if (top_next_ff >= EDGE_NONE) begin
               po_we = 1'b1;
               if (sp_ff != NCW'(1)) begin
                  stk_re = 1'b1;
                  stk_ra = NW'(sp_ff - NCW'(2));
               end
            end else begin
               edge_re = 1'b1;
            end
         end
         DP_EDGE_CHECK: begin
            vis_re = 1'b1;
            vis_ra = tgt_rd_ff;
         end
         DP_VISIT: begin
            if (stat.vis_ok) begin
               vis_we  = 1'b1;
               vis_wa  = t_ff;
               vis_wd  = 1'b1;
               stk_we  = 1'b1;
               stk_wa  = NW'(sp_ff - NCW'(1));
               head_re = 1'b1;
               head_ra = t_ff;
            end
         end
         DP_RELAX_NODE: begin
            po_re = 1'b1;
            po_ra = NW'(ridx_ff - NCW'(1));
         end
         DP_RELAX_U: begin
            head_re = 1'b1;
            head_ra = po_rd_ff;
            best_re = 1'b1;
            best_ra = po_rd_ff;
         end
         DP_RELAX_EDGE: begin
            edge_re = 1'b1;
            edge_ra = e_ff[EW-1:0];
         end
         DP_RELAX_T: begin
            best_re = 1'b1;
            best_ra = tgt_rd_ff;
            nv_re   = 1'b1;
            nv_ra   = tgt_rd_ff;
         end
         DP_RELAX_CMP: begin
            if (better_w) begin
               best_we = 1'b1;
               best_wa = t_ff;
               best_wd = c_ff;
            end
         end
         DP_MAX_READ: begin
            best_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Memories with registered reads
   always_ff @(posedge clock) begin
      if (nv_we) node_value_ff[nv_wa] <= nv_wd;
      if (nv_re) nv_rd_ff <= node_value_ff[nv_ra];
   end

   always_ff @(posedge clock) begin
      if (head_we) edge_head_ff[head_wa] <= head_wd;
      if (head_re) head_rd_ff <= edge_head_ff[head_ra];
   end

   always_ff @(posedge clock) begin
      if (best_we) best_sum_ff[best_wa] <= best_wd;
      if (best_re) best_rd_ff <= best_sum_ff[best_ra];
   end

   always_ff @(posedge clock) begin
      if (vis_we) visited_ff[vis_wa] <= vis_wd;
      if (vis_re) vis_rd_ff <= visited_ff[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_link_ff[ecount_ff[EW-1:0]]   <= head_rd_ff;
         edge_target_ff[ecount_ff[EW-1:0]] <= NW'(req_ff.dest_node);
         edge_weight_ff[ecount_ff[EW-1:0]] <= req_ff.item_value;
      end
      if (edge_re) begin
         link_rd_ff <= edge_link_ff[edge_ra];
         tgt_rd_ff  <= edge_target_ff[edge_ra];
         wgt_rd_ff  <= edge_weight_ff[edge_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (po_we) postorder_ff[pc_ff[NW-1:0]] <= top_node_ff;
      if (po_re) po_rd_ff <= postorder_ff[po_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_ff[stk_wa] <= {top_node_ff, top_next_ff};
      if (stk_re) stk_rd_ff <= stack_ff[stk_ra];
   end

   always_comb begin
      flags_in = flags_ff;
      if (cmd.op == DP_ACCEPT) begin
         if (opcode_type'(req_data.opcode) == OP_CLEAR) flags_in = '0;
         else if (opcode_type'(req_data.opcode) == OP_LOAD_NODE && !src_ok)
            flags_in = flags_ff | 2'b10;
      end else if (cmd.op == DP_EDGE_WRITE) begin
         if (!edge_ok) flags_in = flags_ff | 2'b10;
         else if (ecount_ff == EDGE_NONE) flags_in = flags_ff | 2'b01;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= COUNT_W'(1024);
         flags_ff     <= '0;
         ecount_ff    <= '0;
         cnt_ff       <= '0;
         root_ff      <= '0;
         sp_ff        <= '0;
         pc_ff        <= '0;
         ridx_ff      <= '0;
         prep_wr_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) csr_count_ff <= csr_wr_data;
         flags_ff   <= flags_in;
         prep_wr_ff <= (cmd.op == DP_PREP);
         case (cmd.op)
            DP_CLEAR, DP_PREP, DP_MAX_READ: cnt_ff <= cnt_ff + NCW'(1);
            DP_ACCEPT: begin
               cnt_ff  <= '0;
               root_ff <= '0;
               pc_ff   <= '0;
               if (opcode_type'(req_data.opcode) == OP_CLEAR) ecount_ff <= '0;
            end
            DP_EDGE_WRITE: begin
               if (edge_ok && ecount_ff != EDGE_NONE) ecount_ff <= ecount_ff + EPW'(1);
            end
            DP_ROOT_CHECK: begin
               if (vis_rd_ff) root_ff <= root_ff + NW'(1);
               else sp_ff <= NCW'(1);
            end
            DP_WALK: begin
               if (top_next_ff >= EDGE_NONE) begin
                  pc_ff <= pc_ff + NCW'(1);
                  sp_ff <= sp_ff - NCW'(1);
                  if (sp_ff == NCW'(1)) root_ff <= root_ff + NW'(1);
               end
            end
            DP_PUSH: sp_ff <= sp_ff + NCW'(1);
            DP_RELAX_INIT: begin
               ridx_ff <= pc_ff;
               cnt_ff  <= '0;
            end
            DP_RELAX_NODE: begin
               if (ridx_ff != '0) ridx_ff <= ridx_ff - NCW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prep_addr_ff <= cnt_ff[NW-1:0];
      case (cmd.op)
         DP_ACCEPT: begin
            req_ff  <= req_data;
            best_ff <= '0;
            sat_ff  <= 1'b0;
         end
         DP_ROOT_CHECK: begin
            top_node_ff <= root_ff;
            top_next_ff <= head_rd_ff;
         end
         DP_POP: begin
            top_node_ff <= stk_rd_ff[SW-1:EPW];
            top_next_ff <= stk_rd_ff[EPW-1:0];
         end
         DP_EDGE_CHECK: begin
            top_next_ff <= link_rd_ff;
            t_ff        <= tgt_rd_ff;
         end
         DP_PUSH: begin
            top_node_ff <= t_ff;
            top_next_ff <= head_rd_ff;
         end
         DP_RELAX_U: u_ff <= po_rd_ff;
         DP_RELAX_UDATA: begin
            e_ff  <= head_rd_ff;
            bu_ff <= best_rd_ff;
         end
         DP_RELAX_T: begin
            t_ff    <= tgt_rd_ff;
            e_ff    <= link_rd_ff;
            sum1_ff <= {1'b0, bu_ff} + {33'd0, wgt_rd_ff};
         end
         DP_RELAX_ADD: begin
            c_ff   <= s2_w[64] ? '1 : s2_w[63:0];
            sat_ff <= sat_ff | sum1_ff[64] | s2_w[64];
         end
         DP_RELAX_CMP: begin
            // A self loop feeds the improved sum into later edges of the same node.
            if (better_w && t_ff == u_ff) bu_ff <= c_ff;
         end
         DP_MAX_CMP: begin
            if (best_rd_ff > best_ff) best_ff <= best_rd_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/dag_longest_weighted_path_unit.sv =====
// Heaviest path through a weighted directed graph: loads, then compute on command.
// Top level; depends on dlwp_pkg, dlwp_ctrl and dlwp_datapath.
//
// Items are taken when start is high and busy is low; the result of a compute
// item is shown for exactly one cycle with rsp_valid and cannot be held off.
// A node value load is written as it is taken; for an edge load the edge head
// memory is read as the item is taken, then the edge is written. After reset and
// after every clear item the block sweeps all MAX_NODES entries of the node
// value and edge head memories with busy high. A compute item runs the setup,
// root and maximum scans over the active nodes plus a depth-first walk and a
// relaxation over their edges; every graph memory has a registered read port.
module dag_longest_weighted_path_unit import dlwp_pkg::*; #(
   parameter int unsigned MAX_NODES = 1024,
   parameter int unsigned MAX_EDGES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   dlwp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_data.opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   dlwp_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/dlwp_checker.sv =====
// Checker for the heaviest-path unit: watches the request, result and register ports,
// keeps its own copy of the graph and predicts each compute result. Depends on dlwp_pkg.
module dlwp_checker import dlwp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   output int                 error_count,
   output int                 pending,
   output int                 checked
);
   localparam int NODES = 1024;
   localparam int EDGES = 4096;

   logic [31:0]        node_val [NODES];
   int                 head_edge [NODES];
   int                 next_edge [EDGES];
   logic [9:0]         edge_dst [EDGES];
   logic [31:0]        edge_wt [EDGES];
   int                 edges_used;
   logic [1:0]         err_bits;
   logic [COUNT_W-1:0] node_limit;
   rsp_type            expected_rsp [$];

   assign pending = expected_rsp.size();

   function automatic int live_nodes();
      return (node_limit > NODES) ? NODES : int'(node_limit);
   endfunction

   function automatic void wipe_graph();
      for (int i = 0; i < NODES; i++) begin
         node_val[i] = '0;
         head_edge[i] = EDGES;
      end
      edges_used = 0;
      err_bits = '0;
   endfunction

   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b,
                                                inout bit sat);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
         sat = 1;
         return '1;
      end
      return s[63:0];
   endfunction

   // Depth-first postorder, then one relaxation pass in reverse postorder.
   function automatic rsp_type heaviest_path();
      rsp_type     r;
      int          n, pc, sp, e, t, u;
      bit          seen [NODES];
      int          order [NODES];
      int          stk_node [NODES];
      int          stk_edge [NODES];
      logic [63:0] best [NODES];
      logic [63:0] c, top_sum;
      bit          sat;
      n = live_nodes();
      pc = 0;
      sat = 0;
      top_sum = '0;
      if (n > 0) begin
         for (int i = 0; i < NODES; i++) seen[i] = 0;
         for (int root = 0; root < n; root++) begin
            if (!seen[root]) begin
               seen[root] = 1;
               stk_node[0] = root;
               stk_edge[0] = head_edge[root];
               sp = 1;
               while (sp > 0) begin
                  e = stk_edge[sp-1];
                  if (e >= EDGES) begin
                     if (pc < NODES) begin
                        order[pc] = stk_node[sp-1];
                        pc++;
                     end
                     sp--;
                  end else begin
                     t = edge_dst[e];
                     stk_edge[sp-1] = next_edge[e];
                     if (t < n && !seen[t] && sp < NODES) begin
                        seen[t] = 1;
                        stk_node[sp] = t;
                        stk_edge[sp] = head_edge[t];
                        sp++;
                     end
                  end
               end
            end
         end
         for (int v = 0; v < n; v++) best[v] = {32'd0, node_val[v]};
         for (int i = pc; i > 0; i--) begin
            u = order[i-1];
            e = head_edge[u];
            while (e < EDGES) begin
               t = edge_dst[e];
               if (t < n) begin
                  c = add_clamped(best[u], {32'd0, edge_wt[e]}, sat);
                  c = add_clamped(c, {32'd0, node_val[t]}, sat);
                  if (c > best[t]) best[t] = c;
               end
               e = next_edge[e];
            end
         end
         for (int v = 0; v < n; v++) if (best[v] > top_sum) top_sum = best[v];
      end
      r.longest_weight = top_sum;
      r.saturated = sat;
      r.status = err_bits[1] ? STATUS_RANGE : (err_bits[0] ? STATUS_FULL : STATUS_OK);
      return r;
   endfunction

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      checked = 0;
      node_limit = 11'd1024;
      wipe_graph();
   end

   always @(posedge clock) begin
      int n;
      rsp_type want;
      if (reset) begin
         node_limit = 11'd1024;
         wipe_graph();
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) node_limit = csr_wr_data;
         if (start && !busy) begin
            n = live_nodes();
            case (opcode_type'(req_data.opcode))
               OP_LOAD_NODE: begin
                  if (req_data.source_node < n) node_val[req_data.source_node] = req_data.item_value;
                  else err_bits[1] = 1'b1;
               end
               OP_LOAD_EDGE: begin
                  if (req_data.source_node >= n || req_data.dest_node >= n) begin
                     err_bits[1] = 1'b1;
                  end else if (edges_used >= EDGES) begin
                     err_bits[0] = 1'b1;
                  end else begin
                     edge_dst[edges_used] = req_data.dest_node;
                     edge_wt[edges_used] = req_data.item_value;
                     next_edge[edges_used] = head_edge[req_data.source_node];
                     head_edge[req_data.source_node] = edges_used;
                     edges_used++;
                  end
               end
               OP_COMPUTE: expected_rsp.push_back(heaviest_path());
               OP_CLEAR: wipe_graph();
            endcase
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report("result with no compute outstanding");
            end else begin
               want = expected_rsp.pop_front();
               checked++;
               if (rsp_data.longest_weight !== want.longest_weight)
                  report($sformatf("longest_weight %h, predicted %h",
                                   rsp_data.longest_weight, want.longest_weight));
               if (rsp_data.saturated !== want.saturated)
                  report($sformatf("saturated %b, predicted %b",
                                   rsp_data.saturated, want.saturated));
               if (rsp_data.status !== want.status)
                  report($sformatf("status %0d, predicted %0d", rsp_data.status, want.status));
            end
         end
      end
   end
endmodule

// ===== bench/testbench.sv =====
// Top of the heaviest-path unit bench: clock, reset, stimulus and verdict.
// Depends on dlwp_pkg, dag_longest_weighted_path_unit and dlwp_checker.
module testbench;
   import dlwp_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_wr_en = 0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   int                 error_count, pending, checked;
   int                 cycle_count = 0;
   int                 sent = 0;
   bit                 quiet_tail = 0;

   always #5 clock = ~clock;

   dag_longest_weighted_path_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   dlwp_checker check (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .error_count(error_count), .pending(pending), .checked(checked)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Holds start high until the transfer happens, then maybe idles a burst.
   task automatic issue(input opcode_type op, input int src, input int dst,
                        input logic [31:0] val);
      req_data <= '{opcode: op, source_node: src[9:0], dest_node: dst[9:0], item_value: val};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      if (!quiet_tail && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_nodes(input int count);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly in-range node indexes, now and then anything the field holds.
   function automatic int pick_node(input int count);
      if (count == 0 || $urandom_range(9) == 0) return $urandom_range(1023);
      return $urandom_range(count - 1);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0: return 32'hFFFF_FFFF;
         1: return 32'd0;
         2: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(input int count, input int items);
      int r;
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(99);
         if (r < 42) issue(OP_LOAD_NODE, pick_node(count), 0, pick_value());
         else if (r < 88) issue(OP_LOAD_EDGE, pick_node(count), pick_node(count), pick_value());
         else if (r < 97) issue(OP_COMPUTE, $urandom_range(1023), $urandom_range(1023), $urandom);
         else issue(OP_CLEAR, 0, 0, $urandom);
      end
      issue(OP_COMPUTE, 0, 0, 0);
   endtask

   initial begin
      int sizes [7] = '{3, 8, 1, 16, 5, 64, 1024};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Extremes at the reset node count, including a two-node cycle.
      issue(OP_LOAD_NODE, 0, 1023, 32'hFFFF_FFFF);
      issue(OP_LOAD_NODE, 1023, 0, 32'hFFFF_FFFF);
      issue(OP_LOAD_EDGE, 0, 1023, 32'hFFFF_FFFF);
      issue(OP_LOAD_EDGE, 1023, 0, 32'h0000_0001);
      issue(OP_COMPUTE, 1023, 1023, 32'hFFFF_FFFF);
      issue(OP_CLEAR, 1023, 1023, 32'hFFFF_FFFF);
      issue(OP_COMPUTE, 0, 0, 0);

      // Small graph: refused loads, sticky status, newest-first edges, then stale edges.
      set_nodes(8);
      issue(OP_LOAD_NODE, 8, 0, 32'd5);
      issue(OP_LOAD_EDGE, 1, 9, 32'd5);
      issue(OP_LOAD_NODE, 1, 0, 32'd10);
      issue(OP_LOAD_NODE, 2, 0, 32'd20);
      issue(OP_LOAD_NODE, 7, 0, 32'd7);
      issue(OP_LOAD_EDGE, 1, 2, 32'd3);
      issue(OP_LOAD_EDGE, 1, 7, 32'd100);
      issue(OP_LOAD_EDGE, 2, 7, 32'd1);
      issue(OP_COMPUTE, 0, 0, 0);
      set_nodes(4);
      issue(OP_COMPUTE, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0);
      issue(OP_COMPUTE, 0, 0, 0);

      // A count of zero holds no nodes at all.
      set_nodes(0);
      issue(OP_LOAD_NODE, 0, 0, 32'd1);
      issue(OP_COMPUTE, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0);

      foreach (sizes[i]) begin
         set_nodes(sizes[i]);
         if (i == 6) quiet_tail = 1;
         random_items(sizes[i], (sizes[i] == 1024) ? 90 : 125);
      end

      settle();
      repeat (100) @(posedge clock);
      $display("Sent %0d items over node counts 0 to 1024, with refused loads and clears;",
               sent);
      $display("%0d compute results compared against the prediction.", checked);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
